[design/spcm_pkg.sv]
// Shared types, constants and helper functions for the sky position cross-match block.
// Used by every module of the block; has no dependencies of its own.
package spcm_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int MAX_ENTRIES_DEF    = 32;
  localparam int TRIG_FRAC_BITS_DEF = 30;

  // Fixed field widths
  localparam int ANGLE_W = 24;
  localparam int CFG_W   = 32;
  localparam int ENTRY_W = 5;
  localparam int MUL_W   = 64;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Angle handling: turn-to-radian scale and octant limits
  localparam logic [28:0] RAD_SCALE    = 29'd421657428;
  localparam logic [21:0] EIGHTH_TURN  = 22'h200000;
  localparam logic [22:0] QUARTER_TURN = 23'h400000;

  // Horner steps per polynomial
  localparam int SIN_STEPS = 5;
  localparam int COS_STEPS = 6;

  // Input action codes
  localparam logic [1:0] ACT_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
  localparam logic [1:0] ACT_RUN         = 2'd2;

  // Configuration register indexes
  localparam logic CFG_COS_RADIUS        = 1'b0;
  localparam logic CFG_INCLUDE_UNMATCHED = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD_FIRST,
    CMD_LOAD_SECOND,
    CMD_RUN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [ANGLE_W-1:0]        ra;
    logic [ANGLE_W-1:0]        dec;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                action;
    logic [ANGLE_W-1:0]        right_ascension;
    logic signed [ANGLE_W-1:0] declination;
  } in_item_t;

  typedef struct packed {
    logic               valid_res;
    logic               from_second;
    logic [ENTRY_W-1:0] entry_index;
    logic               replaced;
    logic               last;
  } out_item_t;

  typedef enum logic {
    PH_SIN,
    PH_COS
  } poly_phase_t;

  typedef enum logic [3:0] {
    TG_IDLE,
    TG_XRND,
    TG_X2,
    TG_DM,
    TG_DQ,
    TG_DR,
    TG_HM,
    TG_HN,
    TG_SFIN,
    TG_SSTORE,
    TG_OUT
  } trig_state_t;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_LOAD,
    BK_CLEAR,
    BK_M_RD,
    BK_M_CHK,
    BK_M_TRIG,
    BK_M_MUL1,
    BK_M_MUL2,
    BK_M_MUL3,
    BK_M_CMP,
    BK_M_ADV,
    BK_E_START,
    BK_E1_RD,
    BK_E1_PUT,
    BK_E2_RD,
    BK_E2_PUT,
    BK_EMPTY,
    BK_FINISH
  } back_state_t;

  // Divisor of each Horner step
  function automatic logic [7:0] horner_div(poly_phase_t ph, logic [2:0] step);
    logic [7:0] d;
    d = 8'd1;
    case (ph)
      PH_SIN: begin
        case (step)
          3'd0:    d = 8'd110;
          3'd1:    d = 8'd72;
          3'd2:    d = 8'd42;
          3'd3:    d = 8'd20;
          3'd4:    d = 8'd6;
          default: d = 8'd1;
        endcase
      end
      PH_COS: begin
        case (step)
          3'd0:    d = 8'd132;
          3'd1:    d = 8'd90;
          3'd2:    d = 8'd56;
          3'd3:    d = 8'd30;
          3'd4:    d = 8'd12;
          3'd5:    d = 8'd2;
          default: d = 8'd1;
        endcase
      end
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor) of each Horner step
  function automatic logic [31:0] horner_recip(poly_phase_t ph, logic [2:0] step);
    logic [31:0] m;
    m = 32'hFFFF_FFFF;
    case (ph)
      PH_SIN: begin
        case (step)
          3'd0:    m = 32'd39045157;
          3'd1:    m = 32'd59652323;
          3'd2:    m = 32'd102261126;
          3'd3:    m = 32'd214748364;
          3'd4:    m = 32'd715827882;
          default: m = 32'hFFFF_FFFF;
        endcase
      end
      PH_COS: begin
        case (step)
          3'd0:    m = 32'd32537631;
          3'd1:    m = 32'd47721858;
          3'd2:    m = 32'd76695844;
          3'd3:    m = 32'd143165576;
          3'd4:    m = 32'd357913941;
          3'd5:    m = 32'd2147483648;
          default: m = 32'hFFFF_FFFF;
        endcase
      end
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

[design/spcm_front.sv]
// Front end: accepts input transactions, classifies the action and holds one command.
// Depends on spcm_pkg.
module spcm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spcm_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output spcm_pkg::cmd_t    push_cmd
);
  import spcm_pkg::*;

  logic      cmd_valid_r, cmd_valid_nxt;
  cmd_t      cmd_r, cmd_nxt;
  logic      take;
  logic      keep;
  cmd_kind_t kind;

  // Classify the action; unused codes are dropped
  always_comb begin
    keep = 1'b1;
    kind = CMD_RUN;
    case (in_data.action)
      ACT_LOAD_FIRST:  kind = CMD_LOAD_FIRST;
      ACT_LOAD_SECOND: kind = CMD_LOAD_SECOND;
      ACT_RUN:         kind = CMD_RUN;
      default:         keep = 1'b0;
    endcase
  end

  assign in_ready = !cmd_valid_r || push_ready;
  assign take     = in_valid && in_ready;

  // Hold the command until the queue takes it
  always_comb begin
    cmd_valid_nxt = cmd_valid_r && !push_ready;
    cmd_nxt       = cmd_r;
    if (take) begin
      cmd_valid_nxt = keep;
      cmd_nxt.kind  = kind;
      cmd_nxt.ra    = in_data.right_ascension;
      cmd_nxt.dec   = in_data.declination;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign push_valid = cmd_valid_r;
  assign push_cmd   = cmd_r;

endmodule

[design/spcm_queue.sv]
// Short command queue between the front end and the back end.
// Depends on spcm_pkg.
module spcm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  spcm_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop,
  output spcm_pkg::cmd_t pop_cmd
);
  import spcm_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = cnt_r != CW'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = slot_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

endmodule

[design/spcm_trig.sv]
// Iterative sine/cosine unit: octant reduction and Horner polynomials on one multiplier.
// Depends on spcm_pkg; constant divisions use reciprocal multiply plus one correction.
module spcm_trig #(
  parameter int TRIG_FRAC_BITS = spcm_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [spcm_pkg::ANGLE_W-1:0]     angle,
  output logic                             done,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o
);
  import spcm_pkg::*;

  localparam int F  = TRIG_FRAC_BITS;
  localparam int SH = 50 - F;
  localparam int TW = F + 2;
  localparam int MW = F + 1;

  trig_state_t        state_r, state_nxt;
  poly_phase_t        phase_r, phase_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [1:0]         quad_r, quad_nxt;
  logic               swap_r, swap_nxt;
  logic [F-1:0]       x_r, x_nxt;
  logic [F-1:0]       x2_r, x2_nxt;
  logic [F-1:0]       n_r, n_nxt;
  logic [F-1:0]       q_r, q_nxt;
  logic [MW-1:0]      h_r, h_nxt;
  logic [MW-1:0]      smag_r, smag_nxt;
  logic [MUL_W-1:0]   prod_r, prod_nxt;
  logic signed [TW-1:0] sin_r, sin_nxt;
  logic signed [TW-1:0] cos_r, cos_nxt;
  logic               done_r, done_nxt;

  logic [21:0]        f_off;
  logic [22:0]        t_wide;
  logic [21:0]        t_red;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [7:0]         div_d;
  logic [31:0]        div_m;
  logic [MUL_W-1:0]   prod_rnd;
  logic [F-1:0]       x_new;
  logic [F-1:0]       rem;
  logic [F-1:0]       q_fix;
  logic [MW-1:0]      h_new;
  logic               last_step;
  logic [MW-1:0]      s_mag;
  logic [MW-1:0]      c_mag;
  logic signed [TW-1:0] s_val;
  logic signed [TW-1:0] c_val;

  // Fold the offset into the lower half of the quadrant
  assign f_off  = angle[21:0];
  assign t_wide = QUARTER_TURN - {1'b0, f_off};
  assign t_red  = (f_off <= EIGHTH_TURN) ? f_off : t_wide[21:0];

  assign div_d     = horner_div(phase_r, step_r);
  assign div_m     = horner_recip(phase_r, step_r);
  assign prod_rnd  = prod_r + (MUL_W'(1) << (SH - 1));
  assign x_new     = prod_rnd[SH+F-1:SH];
  assign rem       = n_r - prod_r[F-1:0];
  assign q_fix     = q_r + F'(rem >= F'(div_d));
  assign h_new     = (MW'(1) << F) - {1'b0, q_fix};
  assign last_step = (phase_r == PH_SIN) ? (step_r == 3'(SIN_STEPS - 1))
                                         : (step_r == 3'(COS_STEPS - 1));

  // Undo the octant swap; the quadrant rotation is applied in TG_OUT
  assign s_mag = swap_r ? h_r : smag_r;
  assign c_mag = swap_r ? smag_r : h_r;
  assign s_val = $signed({1'b0, s_mag});
  assign c_val = $signed({1'b0, c_mag});

  // Select multiplier operands, next state and datapath updates
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    quad_nxt  = quad_r;
    swap_nxt  = swap_r;
    x_nxt     = x_r;
    x2_nxt    = x2_r;
    n_nxt     = n_r;
    q_nxt     = q_r;
    h_nxt     = h_r;
    smag_nxt  = smag_r;
    sin_nxt   = sin_r;
    cos_nxt   = cos_r;
    done_nxt  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      TG_IDLE: begin
        mul_a = {10'd0, t_red};
        mul_b = {3'd0, RAD_SCALE};
        if (start) begin
          quad_nxt  = angle[23:22];
          swap_nxt  = f_off > EIGHTH_TURN;
          state_nxt = TG_XRND;
        end
      end
      TG_XRND: begin
        x_nxt     = x_new;
        mul_a     = 32'(x_new);
        mul_b     = 32'(x_new);
        state_nxt = TG_X2;
      end
      TG_X2: begin
        x2_nxt    = prod_r[2*F-1:F];
        n_nxt     = prod_r[2*F-1:F];
        phase_nxt = PH_SIN;
        step_nxt  = '0;
        state_nxt = TG_DM;
      end
      TG_DM: begin
        mul_a     = 32'(n_r);
        mul_b     = div_m;
        state_nxt = TG_DQ;
      end
      TG_DQ: begin
        q_nxt     = prod_r[32+F-1:32];
        mul_a     = 32'(prod_r[32+F-1:32]);
        mul_b     = 32'(div_d);
        state_nxt = TG_DR;
      end
      TG_DR: begin
        h_nxt = h_new;
        if (last_step) begin
          state_nxt = (phase_r == PH_SIN) ? TG_SFIN : TG_OUT;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = TG_HM;
        end
      end
      TG_HM: begin
        mul_a     = 32'(x2_r);
        mul_b     = 32'(h_r);
        state_nxt = TG_HN;
      end
      TG_HN: begin
        n_nxt     = prod_r[2*F-1:F];
        state_nxt = TG_DM;
      end
      TG_SFIN: begin
        mul_a     = 32'(x_r);
        mul_b     = 32'(h_r);
        state_nxt = TG_SSTORE;
      end
      TG_SSTORE: begin
        smag_nxt  = {1'b0, prod_r[2*F-1:F]};
        n_nxt     = x2_r;
        phase_nxt = PH_COS;
        step_nxt  = '0;
        state_nxt = TG_DM;
      end
      TG_OUT: begin
        case (quad_r)
          2'd0: begin
            sin_nxt = s_val;
            cos_nxt = c_val;
          end
          2'd1: begin
            sin_nxt = c_val;
            cos_nxt = -s_val;
          end
          2'd2: begin
            sin_nxt = -s_val;
            cos_nxt = -c_val;
          end
          default: begin
            sin_nxt = -c_val;
            cos_nxt = s_val;
          end
        endcase
        done_nxt  = 1'b1;
        state_nxt = TG_IDLE;
      end
      default: state_nxt = TG_IDLE;
    endcase
    prod_nxt = MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TG_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    phase_r <= phase_nxt;
    step_r  <= step_nxt;
    quad_r  <= quad_nxt;
    swap_r  <= swap_nxt;
    x_r     <= x_nxt;
    x2_r    <= x2_nxt;
    n_r     <= n_nxt;
    q_r     <= q_nxt;
    h_r     <= h_nxt;
    smag_r  <= smag_nxt;
    prod_r  <= prod_nxt;
    sin_r   <= sin_nxt;
    cos_r   <= cos_nxt;
  end

  assign done  = done_r;
  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

[design/spcm_back.sv]
// Back end: list storage, pairwise match scan, record emission and output register.
// Depends on spcm_pkg; drives the shared spcm_trig unit.
module spcm_back #(
  parameter int MAX_ENTRIES    = spcm_pkg::MAX_ENTRIES_DEF,
  parameter int TRIG_FRAC_BITS = spcm_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  input  spcm_pkg::cmd_t                    cmd,
  output logic                              cmd_pop,
  input  logic signed [spcm_pkg::CFG_W-1:0] cos_radius,
  input  logic                              include_unmatched,
  output logic                              trig_start,
  output logic [spcm_pkg::ANGLE_W-1:0]      trig_angle,
  input  logic                              trig_done,
  input  logic signed [TRIG_FRAC_BITS+1:0]  trig_sin,
  input  logic signed [TRIG_FRAC_BITS+1:0]  trig_cos,
  output logic                              out_valid,
  input  logic                              out_ready,
  output spcm_pkg::out_item_t               out_data
);
  import spcm_pkg::*;

  localparam int F   = TRIG_FRAC_BITS;
  localparam int TW  = F + 2;
  localparam int MW  = F + 1;
  localparam int PRW = 2 * MW;
  localparam int DW  = 35;
  localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);

  function automatic logic [MW-1:0] mag_of(logic [TW-1:0] v);
    logic [TW-1:0] m;
    m = v[TW-1] ? -v : v;
    return m[MW-1:0];
  endfunction

  function automatic logic [ENTRY_W-1:0] to_entry(logic [IW-1:0] v);
    logic [IW+ENTRY_W-1:0] e;
    e = {{ENTRY_W{1'b0}}, v};
    return e[ENTRY_W-1:0];
  endfunction

  // List and run memories
  logic [ANGLE_W-1:0] fra_mem  [MAX_ENTRIES];
  logic [TW-1:0]      fsin_mem [MAX_ENTRIES];
  logic [TW-1:0]      fcos_mem [MAX_ENTRIES];
  logic [ANGLE_W-1:0] sra_mem  [MAX_ENTRIES];
  logic [TW-1:0]      ssin_mem [MAX_ENTRIES];
  logic [TW-1:0]      scos_mem [MAX_ENTRIES];
  logic [IW:0]        repl_mem [MAX_ENTRIES];
  logic               clm_mem  [MAX_ENTRIES];

  logic [ANGLE_W-1:0] fra_q, sra_q;
  logic [TW-1:0]      fsin_q, fcos_q, ssin_q, scos_q;
  logic [IW:0]        repl_q;
  logic               clm_q;

  back_state_t        state_r, state_nxt;
  logic [CW-1:0]      fcnt_r, fcnt_nxt;
  logic [CW-1:0]      scnt_r, scnt_nxt;
  logic [CW-1:0]      i1_r, i1_nxt;
  logic [CW-1:0]      i2_r, i2_nxt;
  logic [CW-1:0]      sweep_r, sweep_nxt;
  logic [CW-1:0]      nclm_r, nclm_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;
  logic               tgt_sec_r, tgt_sec_nxt;
  logic [ANGLE_W-1:0] ra_r, ra_nxt;
  logic               best_v_r, best_v_nxt;
  logic [IW-1:0]      best_i_r, best_i_nxt;
  logic signed [TW-1:0] cd_r, cd_nxt;
  logic [PRW-1:0]     prod_r, prod_nxt;
  logic               neg1_r, neg1_nxt;
  logic               neg2_r, neg2_nxt;
  logic               neg3_r, neg3_nxt;
  logic signed [TW-1:0] p1_r, p1_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic [IW-1:0]      f_addr, s_addr;
  logic               f_we, s_we;
  logic               repl_we;
  logic [IW-1:0]      repl_waddr;
  logic [IW:0]        repl_wdata;
  logic               clm_we;
  logic [IW-1:0]      clm_waddr;
  logic               clm_wdata;
  logic               out_free;
  logic [MW-1:0]      m_top;
  logic signed [TW-1:0] p_mag;
  logic signed [TW-1:0] p3;
  logic signed [DW-1:0] dot;
  logic               is_match;
  logic               f_full, s_full;
  logic               i1_last, i2_last;
  logic [CW-1:0]      unclaimed;

  assign f_addr    = i1_r[IW-1:0];
  assign s_addr    = i2_r[IW-1:0];
  assign out_free  = !out_valid_r || out_ready;
  assign f_full    = fcnt_r == CW'(MAX_ENTRIES);
  assign s_full    = scnt_r == CW'(MAX_ENTRIES);
  assign i1_last   = i1_r == fcnt_r - 1'b1;
  assign i2_last   = i2_r == scnt_r - 1'b1;
  assign unclaimed = scnt_r - nclm_r;

  // Dot product of the pair: p1 + p3, scaled to Q1.30 and compared
  assign m_top = prod_r[2*F:F];
  assign p_mag = $signed({1'b0, m_top});
  assign p3    = neg3_r ? -p_mag : p_mag;
  assign dot   = (DW'(p1_r) + DW'(p3)) <<< (30 - F);
  assign is_match = dot >= DW'(cos_radius);

  // Sequence loads, the match scan and record emission
  always_comb begin
    state_nxt     = state_r;
    fcnt_nxt      = fcnt_r;
    scnt_nxt      = scnt_r;
    i1_nxt        = i1_r;
    i2_nxt        = i2_r;
    sweep_nxt     = sweep_r;
    nclm_nxt      = nclm_r;
    rem_nxt       = rem_r;
    tgt_sec_nxt   = tgt_sec_r;
    ra_nxt        = ra_r;
    best_v_nxt    = best_v_r;
    best_i_nxt    = best_i_r;
    cd_nxt        = cd_r;
    prod_nxt      = prod_r;
    neg1_nxt      = neg1_r;
    neg2_nxt      = neg2_r;
    neg3_nxt      = neg3_r;
    p1_nxt        = p1_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    cmd_pop       = 1'b0;
    trig_start    = 1'b0;
    trig_angle    = cmd.dec;
    f_we          = 1'b0;
    s_we          = 1'b0;
    repl_we       = 1'b0;
    repl_waddr    = f_addr;
    repl_wdata    = {best_v_r, best_i_r};
    clm_we        = 1'b0;
    clm_waddr     = s_addr;
    clm_wdata     = 1'b1;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          ra_nxt  = cmd.ra;
          case (cmd.kind)
            CMD_LOAD_FIRST: begin
              if (!f_full) begin
                trig_start  = 1'b1;
                tgt_sec_nxt = 1'b0;
                state_nxt   = BK_LOAD;
              end
            end
            CMD_LOAD_SECOND: begin
              if (!s_full) begin
                trig_start  = 1'b1;
                tgt_sec_nxt = 1'b1;
                state_nxt   = BK_LOAD;
              end
            end
            CMD_RUN: begin
              sweep_nxt = '0;
              state_nxt = BK_CLEAR;
            end
            default: state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_LOAD: begin
        if (trig_done) begin
          if (tgt_sec_r) begin
            s_we     = 1'b1;
            scnt_nxt = scnt_r + 1'b1;
          end else begin
            f_we     = 1'b1;
            fcnt_nxt = fcnt_r + 1'b1;
          end
          state_nxt = BK_IDLE;
        end
      end
      BK_CLEAR: begin
        repl_we    = 1'b1;
        repl_waddr = sweep_r[IW-1:0];
        repl_wdata = '0;
        clm_we     = 1'b1;
        clm_waddr  = sweep_r[IW-1:0];
        clm_wdata  = 1'b0;
        sweep_nxt  = sweep_r + 1'b1;
        if (sweep_r == CW'(MAX_ENTRIES - 1)) begin
          i1_nxt     = '0;
          i2_nxt     = '0;
          best_v_nxt = 1'b0;
          nclm_nxt   = '0;
          state_nxt  = (fcnt_r == '0 || scnt_r == '0) ? BK_E_START : BK_M_RD;
        end
      end
      BK_M_RD: state_nxt = BK_M_CHK;
      BK_M_CHK: begin
        if (clm_q) begin
          state_nxt = BK_M_ADV;
        end else begin
          trig_start = 1'b1;
          trig_angle = fra_q - sra_q;
          state_nxt  = BK_M_TRIG;
        end
      end
      BK_M_TRIG: begin
        if (trig_done) begin
          cd_nxt    = trig_cos;
          state_nxt = BK_M_MUL1;
        end
      end
      BK_M_MUL1: begin
        prod_nxt  = PRW'(mag_of(fsin_q)) * PRW'(mag_of(ssin_q));
        neg1_nxt  = fsin_q[TW-1] ^ ssin_q[TW-1];
        state_nxt = BK_M_MUL2;
      end
      BK_M_MUL2: begin
        p1_nxt    = neg1_r ? -p_mag : p_mag;
        prod_nxt  = PRW'(mag_of(fcos_q)) * PRW'(mag_of(scos_q));
        neg2_nxt  = fcos_q[TW-1] ^ scos_q[TW-1];
        state_nxt = BK_M_MUL3;
      end
      BK_M_MUL3: begin
        prod_nxt  = PRW'(m_top) * PRW'(mag_of(cd_r));
        neg3_nxt  = neg2_r ^ cd_r[TW-1];
        state_nxt = BK_M_CMP;
      end
      BK_M_CMP: begin
        if (is_match) begin
          clm_we     = 1'b1;
          best_v_nxt = 1'b1;
          best_i_nxt = s_addr;
          nclm_nxt   = nclm_r + 1'b1;
        end
        state_nxt = BK_M_ADV;
      end
      BK_M_ADV: begin
        if (i2_last) begin
          repl_we    = 1'b1;
          best_v_nxt = 1'b0;
          i2_nxt     = '0;
          if (i1_last) begin
            state_nxt = BK_E_START;
          end else begin
            i1_nxt    = i1_r + 1'b1;
            state_nxt = BK_M_RD;
          end
        end else begin
          i2_nxt    = i2_r + 1'b1;
          state_nxt = BK_M_RD;
        end
      end
      BK_E_START: begin
        rem_nxt = include_unmatched ? unclaimed : '0;
        i1_nxt  = '0;
        i2_nxt  = '0;
        if (fcnt_r != '0) begin
          state_nxt = BK_E1_RD;
        end else if (include_unmatched && unclaimed != '0) begin
          state_nxt = BK_E2_RD;
        end else begin
          state_nxt = BK_EMPTY;
        end
      end
      BK_E1_RD: state_nxt = BK_E1_PUT;
      BK_E1_PUT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.valid_res   = 1'b1;
          out_nxt.from_second = repl_q[IW];
          out_nxt.entry_index = repl_q[IW] ? to_entry(repl_q[IW-1:0]) : to_entry(f_addr);
          out_nxt.replaced    = repl_q[IW];
          out_nxt.last        = i1_last && rem_r == '0;
          if (i1_last) begin
            state_nxt = (rem_r != '0) ? BK_E2_RD : BK_FINISH;
          end else begin
            i1_nxt    = i1_r + 1'b1;
            state_nxt = BK_E1_RD;
          end
        end
      end
      BK_E2_RD: state_nxt = BK_E2_PUT;
      BK_E2_PUT: begin
        if (clm_q) begin
          i2_nxt    = i2_r + 1'b1;
          state_nxt = BK_E2_RD;
        end else if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.valid_res   = 1'b1;
          out_nxt.from_second = 1'b1;
          out_nxt.entry_index = to_entry(s_addr);
          out_nxt.replaced    = 1'b0;
          out_nxt.last        = rem_r == CW'(1);
          rem_nxt             = rem_r - 1'b1;
          if (rem_r == CW'(1)) begin
            state_nxt = BK_FINISH;
          end else begin
            i2_nxt    = i2_r + 1'b1;
            state_nxt = BK_E2_RD;
          end
        end
      end
      BK_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.last  = 1'b1;
          state_nxt     = BK_FINISH;
        end
      end
      BK_FINISH: begin
        fcnt_nxt  = '0;
        scnt_nxt  = '0;
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      fcnt_r      <= '0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fcnt_r      <= fcnt_nxt;
      scnt_r      <= scnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    i1_r      <= i1_nxt;
    i2_r      <= i2_nxt;
    sweep_r   <= sweep_nxt;
    nclm_r    <= nclm_nxt;
    rem_r     <= rem_nxt;
    tgt_sec_r <= tgt_sec_nxt;
    ra_r      <= ra_nxt;
    best_v_r  <= best_v_nxt;
    best_i_r  <= best_i_nxt;
    cd_r      <= cd_nxt;
    prod_r    <= prod_nxt;
    neg1_r    <= neg1_nxt;
    neg2_r    <= neg2_nxt;
    neg3_r    <= neg3_nxt;
    p1_r      <= p1_nxt;
    out_r     <= out_nxt;
  end

  // First list memory
  always_ff @(posedge clk) begin
    if (f_we) begin
      fra_mem[fcnt_r[IW-1:0]]  <= ra_r;
      fsin_mem[fcnt_r[IW-1:0]] <= trig_sin;
      fcos_mem[fcnt_r[IW-1:0]] <= trig_cos;
    end
    fra_q  <= fra_mem[f_addr];
    fsin_q <= fsin_mem[f_addr];
    fcos_q <= fcos_mem[f_addr];
  end

  // Second list memory
  always_ff @(posedge clk) begin
    if (s_we) begin
      sra_mem[scnt_r[IW-1:0]]  <= ra_r;
      ssin_mem[scnt_r[IW-1:0]] <= trig_sin;
      scos_mem[scnt_r[IW-1:0]] <= trig_cos;
    end
    sra_q  <= sra_mem[s_addr];
    ssin_q <= ssin_mem[s_addr];
    scos_q <= scos_mem[s_addr];
  end

  // Replacement and claim memories
  always_ff @(posedge clk) begin
    if (repl_we) begin
      repl_mem[repl_waddr] <= repl_wdata;
    end
    if (clm_we) begin
      clm_mem[clm_waddr] <= clm_wdata;
    end
    repl_q <= repl_mem[f_addr];
    clm_q  <= clm_mem[s_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[design/sky_position_crossmatch_merge.sv]
// Top level of the sky position cross-match block: configuration registers and wiring
// of front end, command queue, back end and trig unit. Depends on spcm_pkg.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_data   (in_item_t)
//   out_     output     out_valid / out_ready  out_data  (out_item_t)
//   cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// A load is paced by the iterative sine/cosine unit.
// A run first sweeps MAX_ENTRIES entries to clear the claim and replacement memories,
// then runs one trig pass plus three products per pair whose second entry is unclaimed
// and skips both for a claimed one, then emits the records.
// Reset is synchronous and active low; list contents are undefined until loaded.
// The queue lets the front take commands as the back works or output stalls, until full.
module sky_position_crossmatch_merge #(
  parameter int MAX_ENTRIES    = spcm_pkg::MAX_ENTRIES_DEF,
  parameter int TRIG_FRAC_BITS = spcm_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  spcm_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output spcm_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [spcm_pkg::CFG_W-1:0]    cfg_wdata
);
  import spcm_pkg::*;

  logic signed [CFG_W-1:0]          cos_radius_r;
  logic                             incl_r;
  logic                             push_valid, push_ready;
  cmd_t                             push_cmd;
  logic                             pop_valid, pop;
  cmd_t                             pop_cmd;
  logic                             trig_start, trig_done;
  logic [ANGLE_W-1:0]               trig_angle;
  logic signed [TRIG_FRAC_BITS+1:0] trig_sin, trig_cos;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_radius_r <= 32'sd1073741823;
      incl_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COS_RADIUS:        cos_radius_r <= $signed(cfg_wdata);
        CFG_INCLUDE_UNMATCHED: incl_r       <= cfg_wdata[0];
        default:               incl_r       <= incl_r;
      endcase
    end
  end

  spcm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  spcm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  spcm_trig #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_start),
    .angle (trig_angle),
    .done  (trig_done),
    .sin_o (trig_sin),
    .cos_o (trig_cos)
  );

  spcm_back #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (pop_valid),
    .cmd               (pop_cmd),
    .cmd_pop           (pop),
    .cos_radius        (cos_radius_r),
    .include_unmatched (incl_r),
    .trig_start        (trig_start),
    .trig_angle        (trig_angle),
    .trig_done         (trig_done),
    .trig_sin          (trig_sin),
    .trig_cos          (trig_cos),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data)
  );

endmodule
